[rtl/assert_macros.svh]
// Assertion macros used by the RTL of the permutation engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is held off while reset is high.
`define NPE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define NPE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/nperm_pkg.sv]
// Package with shared constants and types of the next permutation engine.
package nperm_pkg;

   // Default capacity and element width.
   localparam int MAX_LEN_DEF    = 16;
   localparam int ELEM_WIDTH_DEF = 32;

   // Fixed width of the element and result value ports.
   localparam int VALUE_WIDTH = 32;

   // Controller states.
   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } nperm_state_type;

endpackage

[rtl/next_permutation_engine.sv]
// Top level of the next permutation engine: element memory, load tracking and result stream.

// The engine takes one element beat per cycle into its element memory, and the beat with
// is_last closes the sequence. While loading it tracks the pivot (the rightmost element
// that is smaller than its right neighbour) and the rightmost tail element that is larger
// than the pivot, so no scan is needed after the close. The next permutation is then read
// out of the memory in order through its single read port, one result beat per cycle when
// the receiver does not stall; each memory read passes the read register and then the
// result register. Input stays stalled from the closing beat until the last memory read
// has moved on to the result register. Elements beyond MAX_LEN are dropped; a dropped
// beat with is_last still closes.

`include "assert_macros.svh"

module next_permutation_engine
   import nperm_pkg::*;
#(
   parameter int MAX_LEN    = MAX_LEN_DEF,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_element_value,
   input  logic                   req_is_last,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_WIDTH-1:0] rsp_result_value,
   output logic                   rsp_result_last,
   output logic                   rsp_wrapped
);

   localparam int IW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);

   // Element memory.
   logic [ELEM_WIDTH-1:0] elem_mem [MAX_LEN];

   // Control registers.
   nperm_state_type state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]   k_ff, k_in;
   logic            has_piv_ff, has_piv_in;
   logic            rd_valid_ff, rd_valid_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [ELEM_WIDTH-1:0]  prev_ff, prev_in;
   logic [ELEM_WIDTH-1:0]  pv_ff, pv_in;
   logic [IW-1:0]          piv_ff, piv_in;
   logic [IW-1:0]          succ_ff, succ_in;
   logic [ELEM_WIDTH-1:0]  rd_data_ff;
   logic                   rd_last_ff, rd_last_in;
   logic                   rd_subst_ff, rd_subst_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_wrap_ff, rsp_wrap_in;

   // Handshake and datapath terms.
   logic                   req_accept;
   logic                   store_en;
   logic                   issue;
   logic                   move;
   logic [IW-1:0]          rd_addr;
   logic [ELEM_WIDTH-1:0]  in_val;
   logic [ELEM_WIDTH-1:0]  out_elem;
   logic [VALUE_WIDTH-1:0] out_ext;
   logic                   new_pivot;
   logic                   new_succ;
   logic [CW:0]            tail_src;
   logic [CW-1:0]          wrap_src;
   logic [CW-1:0]          piv_ext;
   logic [CW-1:0]          src;

   // Fit an input element into the stored element width.
   if (ELEM_WIDTH <= VALUE_WIDTH) begin : g_in_narrow
      assign in_val = req_element_value[ELEM_WIDTH-1:0];
   end else begin : g_in_wide
      assign in_val = {{(ELEM_WIDTH - VALUE_WIDTH){1'b0}}, req_element_value};
   end

   // Sign-extend or cut a stored element to the result width.
   if (ELEM_WIDTH >= VALUE_WIDTH) begin : g_out_wide
      assign out_ext = out_elem[VALUE_WIDTH-1:0];
   end else begin : g_out_narrow
      assign out_ext = {{(VALUE_WIDTH - ELEM_WIDTH){out_elem[ELEM_WIDTH-1]}}, out_elem};
   end

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign store_en   = req_accept && (cnt_ff < CW'(MAX_LEN));

   // Pivot and successor tracking on each stored element.
   assign new_pivot = (cnt_ff != '0) && ($signed(prev_ff) < $signed(in_val));
   assign new_succ  = has_piv_ff && ($signed(pv_ff) < $signed(in_val));

   // Source address of result position k: reversed whole sequence when there is no
   // pivot, else prefix, then the successor at the pivot, then the reversed tail.
   assign piv_ext  = CW'(piv_ff);
   assign wrap_src = cnt_ff - CW'(1) - k_ff;
   assign tail_src = {1'b0, cnt_ff} + {1'b0, piv_ext} - {1'b0, k_ff};
   always_comb begin
      if (!has_piv_ff) begin
         src = wrap_src;
      end else if (k_ff < piv_ext) begin
         src = k_ff;
      end else if (k_ff == piv_ext) begin
         src = CW'(succ_ff);
      end else begin
         src = tail_src[CW-1:0];
      end
   end
   assign rd_addr = src[IW-1:0];

   // Read stage moves into the result register when that is free or being taken.
   assign move     = rd_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign out_elem = rd_subst_ff ? pv_ff : rd_data_ff;

   // Next state and controls.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      k_in        = k_ff;
      has_piv_in  = has_piv_ff;
      prev_in     = prev_ff;
      pv_in       = pv_ff;
      piv_in      = piv_ff;
      succ_in     = succ_ff;
      issue       = 1'b0;
      rd_last_in  = rd_last_ff;
      rd_subst_in = rd_subst_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (store_en) begin
               cnt_in  = cnt_ff + CW'(1);
               prev_in = in_val;
               if (cnt_ff == '0) begin
                  has_piv_in = 1'b0;
               end else if (new_pivot) begin
                  has_piv_in = 1'b1;
                  piv_in     = IW'(cnt_ff - CW'(1));
                  pv_in      = prev_ff;
                  succ_in    = cnt_ff[IW-1:0];
               end else if (new_succ) begin
                  succ_in = cnt_ff[IW-1:0];
               end
            end
            if (req_accept && req_is_last) begin
               state_in = ST_EMIT;
               k_in     = '0;
            end
         end
         ST_EMIT: begin
            if (!rd_valid_ff || move) begin
               if (k_ff != cnt_ff) begin
                  issue       = 1'b1;
                  k_in        = k_ff + CW'(1);
                  rd_last_in  = (k_ff == cnt_ff - CW'(1));
                  rd_subst_in = has_piv_ff && (k_ff > piv_ext) && (src == CW'(succ_ff));
               end else begin
                  state_in = ST_LOAD;
                  cnt_in   = '0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rd_valid_in  = issue || (rd_valid_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && rsp_stall);
   assign rsp_value_in = move ? out_ext : rsp_value_ff;
   assign rsp_last_in  = move ? rd_last_ff : rsp_last_ff;
   assign rsp_wrap_in  = move ? !has_piv_ff : rsp_wrap_ff;

   // Element memory write and registered read.
   always_ff @(posedge clock) begin
      if (store_en) begin
         elem_mem[cnt_ff[IW-1:0]] <= in_val;
      end
      if (issue) begin
         rd_data_ff <= elem_mem[rd_addr];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         k_ff         <= '0;
         has_piv_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         has_piv_ff   <= has_piv_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Tracking and result payload.
   always_ff @(posedge clock) begin
      prev_ff      <= prev_in;
      pv_ff        <= pv_in;
      piv_ff       <= piv_in;
      succ_ff      <= succ_in;
      rd_last_ff   <= rd_last_in;
      rd_subst_ff  <= rd_subst_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_wrap_ff  <= rsp_wrap_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_last  = rsp_last_ff;
   assign rsp_wrapped      = rsp_wrap_ff;

   // Memory reads only happen while a permutation is being streamed out.
   `NPE_ASSERT(a_read_in_emit, clock, reset, rd_valid_ff |-> (state_ff == ST_EMIT), "read stage busy outside emit")
   // The read index never runs past the stored count.
   `NPE_ASSERT(a_k_bound, clock, reset, (state_ff == ST_EMIT) |-> (k_ff <= cnt_ff), "read index past count")
   // The element count never exceeds capacity.
   `NPE_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CW'(MAX_LEN), "element count above capacity")
   // The successor always lies to the right of the pivot.
   `NPE_ASSERT(a_succ_right, clock, reset, has_piv_ff |-> (succ_ff > piv_ff), "successor not right of pivot")

endmodule
